// File: rtl/dvpd_pkg.sv
// Shared types and constants for the posting list varint decoder.
// Used by dvpd_decode, dvpd_result_queue and delta_varint_posting_decoder_core.
package dvpd_pkg;

  localparam int unsigned WordBits    = 32;
  localparam int unsigned IndexBits   = 3;
  localparam int unsigned MaxVarBytes = 5;
  localparam int unsigned GroupBits   = 7;
  localparam logic [7:0]  DataMask    = 8'h7F;
  localparam logic [7:0]  ContBit     = 8'h80;

  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned PtrBits     = $clog2(QueueDepth);
  localparam int unsigned CountBits   = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_POSTING   = 2'd0,
    KIND_OVERLONG  = 2'd1,
    KIND_TRUNCATED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                list_start;
    logic [WordBits-1:0] posting_count;
    logic                buffer_end;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [WordBits-1:0] doc_number;
    logic [WordBits-1:0] term_freq;
    logic                last_of_list;
  } result_t;

  typedef struct packed {
    logic [WordBits-1:0]  accumulator;
    logic [IndexBits-1:0] byte_index;
    logic                 field_phase;
    logic [WordBits-1:0]  held_doc_number;
    logic [WordBits-1:0]  prev_doc_number;
    logic [WordBits-1:0]  remaining;
    logic                 first_posting;
    logic                 halted;
  } state_t;

  // Decoder state after reset: halted, with a fresh first posting pending.
  localparam state_t StateReset = '{
    accumulator:     '0,
    byte_index:      '0,
    field_phase:     1'b0,
    held_doc_number: '0,
    prev_doc_number: '0,
    remaining:       '0,
    first_posting:   1'b1,
    halted:          1'b1
  };

  // Results produced by one byte: count is 0, 1 or 2, filled from r0.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } emit_t;

endpackage

// File: rtl/dvpd_decode.sv
// Per-byte decode logic: next decoder state and the results caused by one byte.
// Depends on dvpd_pkg for the item, state and result types.
module dvpd_decode (
  input  dvpd_pkg::item_t  item,
  input  dvpd_pkg::state_t state,
  output dvpd_pkg::state_t state_next,
  output dvpd_pkg::emit_t  emit
);

  always_comb begin
    dvpd_pkg::state_t       st;
    logic [31:0]            data7;
    logic [31:0]            contrib;
    logic [31:0]            acc;
    dvpd_pkg::result_t      res;
    logic                   done;

    st        = state;
    data7     = {24'b0, item.data_byte & dvpd_pkg::DataMask};
    contrib   = '0;
    acc       = '0;
    res       = '0;
    done      = 1'b0;
    emit      = '0;

    // A list start clears the decode state and loads the posting count.
    if (item.list_start) begin
      st.accumulator     = '0;
      st.byte_index      = '0;
      st.field_phase     = 1'b0;
      st.held_doc_number = '0;
      st.prev_doc_number = '0;
      st.first_posting   = 1'b1;
      st.remaining       = item.posting_count;
      st.halted          = (item.posting_count == '0);
    end

    case (st.byte_index)
      3'd0:    contrib = data7;
      3'd1:    contrib = data7 << dvpd_pkg::GroupBits;
      3'd2:    contrib = data7 << (2 * dvpd_pkg::GroupBits);
      3'd3:    contrib = data7 << (3 * dvpd_pkg::GroupBits);
      3'd4:    contrib = data7 << (4 * dvpd_pkg::GroupBits);
      default: contrib = '0;
    endcase
    acc = st.accumulator | contrib;

    if (!st.halted) begin
      if ((item.data_byte & dvpd_pkg::ContBit) != 8'h00) begin
        if (st.byte_index >= dvpd_pkg::IndexBits'(dvpd_pkg::MaxVarBytes - 1)) begin
          // Fifth byte still continues: the varint is overlong.
          res.kind         = dvpd_pkg::KIND_OVERLONG;
          res.last_of_list = 1'b1;
          emit.r0          = res;
          emit.count       = 2'd1;
          st.accumulator   = acc;
          st.halted        = 1'b1;
          done             = 1'b1;
        end else begin
          st.accumulator = acc;
          st.byte_index  = st.byte_index + 3'd1;
        end
      end else begin
        st.accumulator = '0;
        st.byte_index  = '0;
        if (!st.field_phase) begin
          st.held_doc_number = st.first_posting ? acc : st.prev_doc_number + acc;
          st.field_phase     = 1'b1;
        end else begin
          st.field_phase     = 1'b0;
          st.prev_doc_number = st.held_doc_number;
          st.first_posting   = 1'b0;
          res.kind           = dvpd_pkg::KIND_POSTING;
          res.doc_number     = st.held_doc_number;
          res.term_freq      = acc;
          res.last_of_list   = (st.remaining == 32'd1);
          emit.r0            = res;
          emit.count         = 2'd1;
          st.remaining       = st.remaining - 32'd1;
          if (res.last_of_list) begin
            st.halted = 1'b1;
            done      = 1'b1;
          end
        end
      end

      if (!done && item.buffer_end) begin
        // Buffer ran out with postings still expected.
        res              = '0;
        res.kind         = dvpd_pkg::KIND_TRUNCATED;
        res.last_of_list = 1'b1;
        if (emit.count == 2'd0) begin
          emit.r0 = res;
        end else begin
          emit.r1 = res;
        end
        emit.count = emit.count + 2'd1;
        st.halted  = 1'b1;
      end
    end

    state_next = st;
  end

endmodule

// File: rtl/dvpd_result_queue.sv
// Small result queue that takes up to two results a cycle and hands out one word per cycle while m_tready is high.
// Depends on dvpd_pkg for the result and emit types and the queue depth.
module dvpd_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  dvpd_pkg::emit_t   push,
  output logic              room,
  output logic              m_tvalid,
  input  logic              m_tready,
  output dvpd_pkg::result_t head
);

  dvpd_pkg::result_t                  entries [dvpd_pkg::QueueDepth];
  logic [dvpd_pkg::PtrBits-1:0]       wr_ptr;
  logic [dvpd_pkg::PtrBits-1:0]       rd_ptr;
  logic [dvpd_pkg::CountBits-1:0]     count;
  logic [dvpd_pkg::CountBits-1:0]     count_next;
  logic                               pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = entries[rd_ptr];
  // Space for the worst case of two results from one byte.
  assign room     = (count <= dvpd_pkg::CountBits'(dvpd_pkg::QueueDepth - 2));

  assign count_next = count + dvpd_pkg::CountBits'(push.count)
                      - dvpd_pkg::CountBits'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + dvpd_pkg::PtrBits'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dvpd_pkg::PtrBits'(push.count);
      rd_ptr <= rd_ptr + dvpd_pkg::PtrBits'(pop);
      count  <= count_next;
    end
  end

endmodule

// File: rtl/delta_varint_posting_decoder_core.sv
// Posting list decoder: one compressed byte per input word, (document, frequency) words out.
// A byte is held in the input register until the result queue has room, then decoded and
// written into the queue; its first result is then presented on m_*.
// Throughput: one byte per cycle while the queue has room; a byte that yields two results
// (a posting and a truncation error) leaves as two words over the single output port.
// Reset (rst, synchronous): decoder idles until a list start, input register and queue empty.
module delta_varint_posting_decoder_core (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] posting_count
  input  logic        s_tuser,   // [0] list_start
  input  logic        s_tlast,   // buffer_end
  // Decoded result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] doc_number, [63:32] term_freq
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_of_list
);

  // Input register: holds one accepted byte until the queue has room for its results.
  logic              in_valid;
  dvpd_pkg::item_t   in_item;
  logic              s_accept;
  logic              advance;

  // Decoder state, updated only when the held byte is decoded.
  dvpd_pkg::state_t  state;
  dvpd_pkg::state_t  state_next;
  dvpd_pkg::emit_t   emit;
  dvpd_pkg::emit_t   push;

  logic              room;
  dvpd_pkg::result_t head;

  // The held byte moves on whenever the queue can take two more results, so the
  // input side keeps running while earlier results wait on the output.
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.data_byte     <= s_tdata[7:0];
      in_item.posting_count <= s_tdata[39:8];
      in_item.list_start    <= s_tuser;
      in_item.buffer_end    <= s_tlast;
    end
  end

  dvpd_decode u_decode (
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .emit       (emit)
  );

  // Reset leaves the decoder halted with a fresh first posting pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvpd_pkg::StateReset;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_comb begin
    push = emit;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  dvpd_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {head.term_freq, head.doc_number};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_list;

`ifndef SYNTHESIS
  // Two results from one byte only happen as a posting followed by a truncation error.
  a_second_is_trunc: assert property (@(posedge clk) disable iff (rst)
    (advance && emit.count == 2'd2) |->
      (emit.r0.kind == dvpd_pkg::KIND_POSTING && emit.r1.kind == dvpd_pkg::KIND_TRUNCATED))
    else $error("second result of a byte is not a truncation error");

  // Every error result closes its list.
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (advance && emit.count != 2'd0 && emit.r0.kind != dvpd_pkg::KIND_POSTING)
      |-> emit.r0.last_of_list)
    else $error("error result without last_of_list");

  // The varint byte counter never runs past the fifth byte.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state.byte_index <= dvpd_pkg::IndexBits'(dvpd_pkg::MaxVarBytes - 1))
    else $error("byte_index out of range");

  // A halted decoder stays silent until a list start.
  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && state.halted && !in_item.list_start) |-> (emit.count == 2'd0))
    else $error("result emitted while halted");

  // A stalled input side means a byte is held waiting for queue space.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && !room))
    else $error("input stalled without a held byte");
`endif

endmodule
